[hw/rtl/mcie_pkg.sv]
// Shared types and constants for the mid-range instruction execute block.
// Holds the decoded instruction format, the result layout and field constants.
// No dependencies.
`default_nettype none

package mcie_pkg;

  localparam int unsigned FileBytes  = 512;
  localparam int unsigned AddrW      = $clog2(FileBytes);
  localparam int unsigned InstrW     = 14;
  localparam int unsigned PcW        = 13;
  localparam int unsigned LitW       = 11;
  localparam int unsigned QueueDepth = 2;

  localparam logic [6:0]       StatusF    = 7'h03;
  localparam logic [AddrW-1:0] PclathAddr = 9'h00A;
  localparam logic [PcW-1:0]   PcReset    = 13'd1;

  localparam int unsigned FlagC  = 0;
  localparam int unsigned FlagDc = 1;
  localparam int unsigned FlagZ  = 2;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MOVWF,
    OP_CLRW,
    OP_CLRF,
    OP_MOVF,
    OP_INCF,
    OP_BCF,
    OP_BSF,
    OP_BTFSC,
    OP_GOTO,
    OP_MOVLW,
    OP_SUBLW,
    OP_BAD
  } op_kind_t;

  // lit holds instruction bits 10:0: f in 6:0, d in 7, bit in 9:7, k in 7:0
  typedef struct packed {
    op_kind_t        kind;
    logic [LitW-1:0] lit;
  } uop_t;

  typedef struct packed {
    logic             unsupported;
    logic             skipped;
    logic [7:0]       write_data;
    logic [AddrW-1:0] write_address;
    logic             write_valid;
    logic [7:0]       status_value;
    logic [7:0]       w_value;
    logic [PcW-1:0]   next_pc;
  } result_t;

  function automatic logic writes_file(uop_t u);
    logic wr;
    wr = (u.kind == OP_MOVWF) || (u.kind == OP_CLRF) || (u.kind == OP_BCF) ||
         (u.kind == OP_BSF) || (((u.kind == OP_MOVF) || (u.kind == OP_INCF)) && u.lit[7]);
    return wr;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mcie_decode.sv]
// Front end: accepts instruction beats and classifies the opcode.
// Depends on mcie_pkg.
`default_nettype none

module mcie_decode (
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [mcie_pkg::InstrW-1:0] instruction,
  input  wire logic                        q_full,
  output logic                             push,
  output mcie_pkg::uop_t                   push_uop
);
  import mcie_pkg::*;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    push_uop.lit  = instruction[LitW-1:0];
    push_uop.kind = OP_BAD;
    unique case (instruction[13:12])
      2'b00: begin
        unique case (instruction[11:8])
          4'h0: begin
            if (instruction[7]) begin
              push_uop.kind = OP_MOVWF;
            end else if (instruction[4:0] == 5'd0) begin
              push_uop.kind = OP_NOP;
            end
          end
          4'h1: push_uop.kind = instruction[7] ? OP_CLRF : OP_CLRW;
          4'h8: push_uop.kind = OP_MOVF;
          4'hA: push_uop.kind = OP_INCF;
          default: push_uop.kind = OP_BAD;
        endcase
      end
      2'b01: begin
        unique case (instruction[11:10])
          2'b00: push_uop.kind = OP_BCF;
          2'b01: push_uop.kind = OP_BSF;
          2'b10: push_uop.kind = OP_BTFSC;
          2'b11: push_uop.kind = OP_BAD;
        endcase
      end
      2'b10: push_uop.kind = instruction[11] ? OP_GOTO : OP_BAD;
      2'b11: begin
        unique case (instruction[11:8])
          4'h0, 4'h1, 4'h2, 4'h3: push_uop.kind = OP_MOVLW;
          4'hC, 4'hD:             push_uop.kind = OP_SUBLW;
          default:                push_uop.kind = OP_BAD;
        endcase
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/mcie_queue.sv]
// Short FIFO of decoded instructions between the front end and the execute unit.
// Depends on mcie_pkg.
`default_nettype none

module mcie_queue #(
  parameter int unsigned DEPTH = mcie_pkg::QueueDepth
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mcie_pkg::uop_t push_uop,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output mcie_pkg::uop_t      head_uop
);
  import mcie_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  uop_t            slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_uop   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_uop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mcie_exec.sv]
// Back end: file memory read stage, execute stage and result register.
// Holds W, STATUS, PCLATH shadow, program counter and the 512-byte file memory.
// Depends on mcie_pkg.
`default_nettype none

module mcie_exec (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire mcie_pkg::uop_t q_uop,
  output logic                q_pop,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output mcie_pkg::result_t   m_result
);
  import mcie_pkg::*;

  logic [7:0]       file_mem [FileBytes];
  logic             clearing;
  logic [AddrW-1:0] clr_idx;

  logic [7:0]       status;
  logic [7:0]       w;
  logic [PcW-1:0]   pc;
  logic [7:0]       pclath;

  logic             s2_valid;
  uop_t             s2_uop;
  logic [7:0]       rdata;
  logic             s2_fwd;
  logic [7:0]       s2_fwd_data;

  logic [AddrW-1:0] s1_addr;
  logic [AddrW-1:0] s2_addr;
  logic             s2_is_status;
  logic             s2_wr;
  logic             s2_exec;
  logic             s1_adv;

  logic [7:0]       fval;
  logic [7:0]       mask;
  logic [7:0]       inc_val;
  logic [8:0]       sub_val;
  logic [7:0]       wdata;
  logic [7:0]       w_next;
  logic [PcW-1:0]   pc_next;
  logic [7:0]       status_next;
  logic [7:0]       st_base;
  logic             skip;
  logic             bad;
  logic             z_upd;
  logic             z_val;
  logic             cdc_upd;

  assign s1_addr      = {status[6:5], q_uop.lit[6:0]};
  assign s2_addr      = {status[6:5], s2_uop.lit[6:0]};
  assign s2_is_status = (s2_uop.lit[6:0] == StatusF);
  assign s2_wr        = writes_file(s2_uop);
  assign s2_exec      = s2_valid && (!m_tvalid || m_tready);
  // hold the read stage while the instruction ahead may change the bank bits
  assign s1_adv       = q_valid && !clearing && (!s2_valid || s2_exec) &&
                        !(s2_valid && s2_wr && s2_is_status);
  assign q_pop        = s1_adv;

  always_comb begin
    fval    = s2_is_status ? status : (s2_fwd ? s2_fwd_data : rdata);
    mask    = 8'b1 << s2_uop.lit[9:7];
    inc_val = fval + 8'd1;
    sub_val = {1'b0, s2_uop.lit[7:0]} - {1'b0, w};
    w_next  = w;
    pc_next = pc + 1'b1;
    wdata   = 8'd0;
    skip    = 1'b0;
    bad     = 1'b0;
    z_upd   = 1'b0;
    z_val   = 1'b0;
    cdc_upd = 1'b0;
    unique case (s2_uop.kind)
      OP_NOP: begin
      end
      OP_MOVWF: wdata = w;
      OP_CLRW: begin
        w_next = 8'd0;
        z_upd  = 1'b1;
        z_val  = 1'b1;
      end
      OP_CLRF: begin
        z_upd = 1'b1;
        z_val = 1'b1;
      end
      OP_MOVF: begin
        wdata = fval;
        if (!s2_uop.lit[7]) begin
          w_next = fval;
        end
        z_upd = 1'b1;
        z_val = (fval == 8'd0);
      end
      OP_INCF: begin
        wdata = inc_val;
        if (!s2_uop.lit[7]) begin
          w_next = inc_val;
        end
        z_upd = 1'b1;
        z_val = (inc_val == 8'd0);
      end
      OP_BCF: wdata = fval & ~mask;
      OP_BSF: wdata = fval | mask;
      OP_BTFSC: begin
        if ((fval & mask) == 8'd0) begin
          skip    = 1'b1;
          pc_next = pc + 2'd2;
        end
      end
      OP_GOTO: pc_next = {pclath[4:3], s2_uop.lit};
      OP_MOVLW: w_next = s2_uop.lit[7:0];
      OP_SUBLW: begin
        w_next  = sub_val[7:0];
        z_upd   = 1'b1;
        z_val   = (sub_val[7:0] == 8'd0);
        cdc_upd = 1'b1;
      end
      default: begin
        bad     = 1'b1;
        pc_next = pc;
      end
    endcase

    st_base     = (s2_wr && s2_is_status) ? wdata : status;
    status_next = st_base;
    if (z_upd) begin
      status_next[FlagZ] = z_val;
    end
    if (cdc_upd) begin
      status_next[FlagC]  = !sub_val[8];
      status_next[FlagDc] = (s2_uop.lit[3:0] >= w[3:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      file_mem[clr_idx] <= 8'd0;
    end else if (s2_exec && s2_wr) begin
      file_mem[s2_addr] <= wdata;
    end
    if (s1_adv) begin
      rdata       <= file_mem[s1_addr];
      s2_uop      <= q_uop;
      s2_fwd      <= s2_exec && s2_wr && (s2_addr == s1_addr);
      s2_fwd_data <= wdata;
    end
    if (s2_exec) begin
      m_result.next_pc       <= pc_next;
      m_result.w_value       <= w_next;
      m_result.status_value  <= status_next;
      m_result.write_valid   <= s2_wr;
      m_result.write_address <= s2_wr ? s2_addr : '0;
      m_result.write_data    <= s2_wr ? (s2_is_status ? status_next : wdata) : 8'd0;
      m_result.skipped       <= skip;
      m_result.unsupported   <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
      status   <= 8'd0;
      w        <= 8'd0;
      pc       <= PcReset;
      pclath   <= 8'd0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == AddrW'(FileBytes - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_exec) begin
        s2_valid <= 1'b0;
      end
      if (s2_exec) begin
        m_tvalid <= 1'b1;
        status   <= status_next;
        w        <= w_next;
        pc       <= pc_next;
        if (s2_wr && (s2_addr == PclathAddr)) begin
          pclath <= wdata;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_issue_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_adv)
    else $error("instruction issued during memory clear");

  a_bad_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (s2_exec && (s2_uop.kind == OP_BAD)) |=> (pc == $past(pc)) && (w == $past(w)))
    else $error("unsupported opcode changed pc or w");

  a_exec_fills_output: assert property (@(posedge clk) disable iff (rst)
    s2_exec |=> m_tvalid)
    else $error("executed instruction produced no result");

  a_bank_stable_on_issue: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s2_valid) |=> (status[6:5] == $past(status[6:5])))
    else $error("bank changed under an issued read");
`endif

endmodule

`default_nettype wire

[hw/rtl/midrange_core_instruction_execute.sv]
// Top level of the mid-range instruction execute block.
// Uses mcie_pkg, mcie_decode, mcie_queue and mcie_exec.
//
// Input stream: one 14-bit instruction word per beat in s_tdata[13:0].
// Output stream: one result beat per instruction with the new PC, W, STATUS,
// the file write made (if any), the skip flag and the unsupported flag.
// Path: queue slot, then the read-stage register, then the result register on m_tvalid.
// Throughput: one instruction per cycle while m_tready is high; an instruction that writes
// STATUS holds back the next file read until it executes, since that read needs its bank.
// The file memory has one read and one write per cycle; a read of the address
// written by the instruction just ahead takes the forwarded byte.
// Reset: W, STATUS and PCLATH go to zero and the PC to one; then the 512-byte
// file memory is cleared one byte per cycle before any instruction executes
// (beats are still queued while s_tready is high).
// Stall: with m_tready low the result register holds, execution stops, the
// decoded-instruction queue fills and s_tready drops.
`default_nettype none

module midrange_core_instruction_execute #(
  parameter int unsigned QUEUE_DEPTH = mcie_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // instruction [13:0], zero [15:14]
  input  wire logic [15:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // next_pc [12:0], w_value [20:13], status_value [28:21], write_valid [29],
  // write_address [38:30], write_data [46:39], skipped [47], unsupported [48],
  // zero [55:49]
  output logic [55:0]      m_tdata
);
  import mcie_pkg::*;

  logic    push;
  uop_t    push_uop;
  logic    q_full;
  logic    q_pop;
  logic    q_valid;
  uop_t    q_uop;
  result_t result;

  mcie_decode u_decode (
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .instruction (s_tdata[InstrW-1:0]),
    .q_full      (q_full),
    .push        (push),
    .push_uop    (push_uop)
  );

  mcie_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_uop   (push_uop),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_uop   (q_uop)
  );

  mcie_exec u_exec (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_uop    (q_uop),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_result (result)
  );

  assign m_tdata = {7'd0, result};

endmodule

`default_nettype wire

[tb/tb_midrange_core_instruction_execute.sv]
// Testbench for midrange_core_instruction_execute: directed and random programs.
// Each result beat is compared field by field with an in-bench instruction executor.
// Depends on mcie_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_midrange_core_instruction_execute;
  import mcie_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 250000;

  localparam logic [13:0] OPC_NOP     = 14'h0000;
  localparam logic [13:0] OPC_MOVWF   = 14'h0080;
  localparam logic [13:0] OPC_CLRW    = 14'h0100;
  localparam logic [13:0] OPC_CLRF    = 14'h0180;
  localparam logic [13:0] OPC_MOVF    = 14'h0800;
  localparam logic [13:0] OPC_INCF    = 14'h0A00;
  localparam logic [13:0] OPC_BCF     = 14'h1000;
  localparam logic [13:0] OPC_BSF     = 14'h1400;
  localparam logic [13:0] OPC_BTFSC   = 14'h1800;
  localparam logic [13:0] OPC_BTFSS   = 14'h1C00;
  localparam logic [13:0] OPC_CALL    = 14'h2000;
  localparam logic [13:0] OPC_GOTO    = 14'h2800;
  localparam logic [13:0] OPC_MOVLW   = 14'h3000;
  localparam logic [13:0] OPC_SUBLW   = 14'h3C00;
  localparam logic [13:0] OPC_LIT_BAD = 14'h3E00;

  localparam logic [13:0] MASK_NOP   = 14'h3F9F;
  localparam logic [13:0] MASK_DEST  = 14'h3F80;
  localparam logic [13:0] MASK_BYTE  = 14'h3F00;
  localparam logic [13:0] MASK_BIT   = 14'h3C00;
  localparam logic [13:0] MASK_GOTO  = 14'h3800;
  localparam logic [13:0] MASK_SUBLW = 14'h3E00;

  localparam logic [AddrW-1:0] STATUS_ADDR = {2'b00, StatusF};

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;

  logic [7:0]     file_mem [FileBytes];
  logic [7:0]     w_reg;
  logic [PcW-1:0] pc_reg;

  result_t pending_results[$];
  result_t got;
  result_t want;
  int      fail_count  = 0;
  int      cycle_count = 0;
  bit      send_idle_on;
  bit      recv_idle_on;

  midrange_core_instruction_execute dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic op_kind_t decode_kind(input logic [13:0] ins);
    if ((ins & MASK_NOP) == OPC_NOP) return OP_NOP;
    if ((ins & MASK_DEST) == OPC_MOVWF) return OP_MOVWF;
    if ((ins & MASK_DEST) == OPC_CLRW) return OP_CLRW;
    if ((ins & MASK_DEST) == OPC_CLRF) return OP_CLRF;
    if ((ins & MASK_BYTE) == OPC_MOVF) return OP_MOVF;
    if ((ins & MASK_BYTE) == OPC_INCF) return OP_INCF;
    if ((ins & MASK_BIT) == OPC_BCF) return OP_BCF;
    if ((ins & MASK_BIT) == OPC_BSF) return OP_BSF;
    if ((ins & MASK_BIT) == OPC_BTFSC) return OP_BTFSC;
    if ((ins & MASK_GOTO) == OPC_GOTO) return OP_GOTO;
    if ((ins & MASK_BIT) == OPC_MOVLW) return OP_MOVLW;
    if ((ins & MASK_SUBLW) == OPC_SUBLW) return OP_SUBLW;
    return OP_BAD;
  endfunction

  // Execute one word against the bench copy of W, PC and the file memory.
  function automatic result_t execute_instr(input logic [13:0] ins);
    result_t          res;
    logic [1:0]       bank;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] saddr;
    logic [2:0]       bitn;
    logic [7:0]       k;
    logic [7:0]       v;
    logic [7:0]       w_old;
    logic [PcW-1:0]   pc_n;
    logic             ok;
    logic             wrote;
    logic             skip;
    bank  = file_mem[STATUS_ADDR][6:5];
    addr  = {bank, ins[6:0]};
    saddr = {bank, StatusF};
    bitn  = ins[9:7];
    k     = ins[7:0];
    pc_n  = pc_reg + 13'd1;
    ok    = 1'b1;
    wrote = 1'b0;
    skip  = 1'b0;
    case (decode_kind(ins))
      OP_NOP: ;
      OP_MOVWF: begin
        file_mem[addr] = w_reg;
        wrote = 1'b1;
      end
      OP_CLRW: begin
        w_reg = 8'h00;
        file_mem[saddr][FlagZ] = 1'b1;
      end
      OP_CLRF: begin
        file_mem[addr] = 8'h00;
        wrote = 1'b1;
        file_mem[saddr][FlagZ] = 1'b1;
      end
      OP_MOVF, OP_INCF: begin
        v = (decode_kind(ins) == OP_INCF) ? file_mem[addr] + 8'd1 : file_mem[addr];
        if (ins[7]) begin
          file_mem[addr] = v;
          wrote = 1'b1;
        end else begin
          w_reg = v;
        end
        file_mem[saddr][FlagZ] = (v == 8'h00);
      end
      OP_BCF: begin
        file_mem[addr][bitn] = 1'b0;
        wrote = 1'b1;
      end
      OP_BSF: begin
        file_mem[addr][bitn] = 1'b1;
        wrote = 1'b1;
      end
      OP_BTFSC: begin
        if (!file_mem[addr][bitn]) begin
          skip = 1'b1;
          pc_n = pc_n + 13'd1;
        end
      end
      OP_GOTO: pc_n = {file_mem[PclathAddr][4:3], ins[10:0]};
      OP_MOVLW: w_reg = k;
      OP_SUBLW: begin
        w_old = w_reg;
        w_reg = k - w_old;
        file_mem[saddr][FlagDc] = (k[3:0] >= w_old[3:0]);
        file_mem[saddr][FlagC]  = (k >= w_old);
        file_mem[saddr][FlagZ]  = (w_reg == 8'h00);
      end
      default: ok = 1'b0;
    endcase
    if (ok) begin
      v = file_mem[saddr];
      for (int b = 0; b < 4; b++) file_mem[{b[1:0], StatusF}] = v;
      pc_reg = pc_n;
    end
    res.next_pc       = pc_reg;
    res.w_value       = w_reg;
    res.status_value  = file_mem[STATUS_ADDR];
    res.write_valid   = wrote;
    res.write_address = wrote ? addr : '0;
    res.write_data    = wrote ? file_mem[addr] : 8'h00;
    res.skipped       = skip;
    res.unsupported   = !ok;
    return res;
  endfunction

  // sel carries d for byte ops, the bit number for bit ops, the form for bad words
  function automatic logic [13:0] encode(input op_kind_t kind, input logic [6:0] f,
                                         input logic [2:0] sel, input logic [10:0] lit);
    case (kind)
      OP_NOP:   return OPC_NOP | {7'd0, f[6:5], 5'd0};
      OP_MOVWF: return OPC_MOVWF | {7'd0, f};
      OP_CLRW:  return OPC_CLRW | {7'd0, f};
      OP_CLRF:  return OPC_CLRF | {7'd0, f};
      OP_MOVF:  return OPC_MOVF | {6'd0, sel[0], f};
      OP_INCF:  return OPC_INCF | {6'd0, sel[0], f};
      OP_BCF:   return OPC_BCF | {4'd0, sel, f};
      OP_BSF:   return OPC_BSF | {4'd0, sel, f};
      OP_BTFSC: return OPC_BTFSC | {4'd0, sel, f};
      OP_GOTO:  return OPC_GOTO | {3'd0, lit};
      OP_MOVLW: return OPC_MOVLW | {4'd0, lit[9:0]};
      OP_SUBLW: return OPC_SUBLW | {5'd0, lit[8:0]};
      default: begin
        case (sel)
          3'd0:    return OPC_NOP | {7'd0, f | 7'h01};
          3'd1:    return {2'b00, lit[10], 1'b1, lit[9:0]};
          3'd2:    return OPC_BTFSS | {4'd0, lit[9:0]};
          3'd3:    return OPC_CALL | {3'd0, lit};
          3'd4:    return {2'b11, lit[10] ? 2'b10 : 2'b01, lit[9:0]};
          default: return OPC_LIT_BAD | {5'd0, lit[8:0]};
        endcase
      end
    endcase
  endfunction

  function automatic logic [13:0] rand_instr();
    int unsigned r;
    logic [6:0]  f;
    op_kind_t    kind;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 7))
      0:       f = StatusF;
      1:       f = PclathAddr[6:0];
      default: f = 7'($urandom_range(0, 127));
    endcase
    if (r < 8) return 14'($urandom);
    kind = (r < 16) ? OP_BAD : op_kind_t'($urandom_range(int'(OP_NOP), int'(OP_SUBLW)));
    return encode(kind, f, 3'($urandom_range(0, 7)), 11'($urandom_range(0, 2047)));
  endfunction

  task automatic send_instr(input logic [13:0] ins);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, ins};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(execute_instr(ins));
  endtask

  task automatic hold_until_retired();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_literal_alu();
    send_instr(encode(OP_MOVLW, 7'd0, 3'd0, 11'h3FF));
    send_instr(encode(OP_SUBLW, 7'd0, 3'd0, 11'h010));
    send_instr(encode(OP_SUBLW, 7'd0, 3'd0, 11'h011));
    send_instr(encode(OP_CLRW, 7'h7F, 3'd0, 11'd0));
  endtask

  task automatic test_file_regs();
    send_instr(encode(OP_MOVLW, 7'd0, 3'd0, 11'h0FF));
    send_instr(encode(OP_MOVWF, 7'h7F, 3'd0, 11'd0));
    send_instr(encode(OP_INCF, 7'h7F, 3'd1, 11'd0));
    send_instr(encode(OP_MOVF, 7'h7F, 3'd0, 11'd0));
    send_instr(encode(OP_CLRF, 7'h20, 3'd0, 11'd0));
    send_instr(encode(OP_MOVF, 7'h00, 3'd1, 11'd0));
  endtask

  task automatic test_bits_banks();
    send_instr(encode(OP_BSF, StatusF, 3'd5, 11'd0));
    send_instr(encode(OP_BSF, StatusF, 3'd6, 11'd0));
    send_instr(encode(OP_INCF, StatusF, 3'd1, 11'd0));
    send_instr(encode(OP_BSF, 7'h7F, 3'd7, 11'd0));
    send_instr(encode(OP_BTFSC, 7'h7F, 3'd7, 11'd0));
    send_instr(encode(OP_BCF, 7'h7F, 3'd7, 11'd0));
    send_instr(encode(OP_BTFSC, 7'h7F, 3'd7, 11'd0));
    send_instr(encode(OP_CLRF, StatusF, 3'd0, 11'd0));
  endtask

  task automatic test_branch();
    send_instr(encode(OP_MOVLW, 7'd0, 3'd0, 11'h018));
    send_instr(encode(OP_MOVWF, PclathAddr[6:0], 3'd0, 11'd0));
    send_instr(encode(OP_GOTO, 7'd0, 3'd0, 11'h7FF));
    send_instr(encode(OP_NOP, 7'h60, 3'd0, 11'd0));
    send_instr(encode(OP_GOTO, 7'd0, 3'd0, 11'h7FE));
    send_instr(encode(OP_BTFSC, 7'h20, 3'd0, 11'd0));
  endtask

  task automatic test_unsupported();
    for (int s = 0; s < 6; s++) send_instr(encode(OP_BAD, 7'h7F, 3'(s), 11'h7FF));
  endtask

  task automatic test_random_program(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        send_idle_on = $urandom_range(0, 1);
        recv_idle_on = $urandom_range(0, 1);
      end
      if (i == count / 2) hold_until_retired();
      send_instr(rand_instr());
    end
  endtask

  initial begin
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = recv_idle_on ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $error("result beat with no instruction outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.next_pc != want.next_pc) begin
          $error("next_pc expected %h got %h", want.next_pc, got.next_pc);
          fail_count++;
        end
        if (got.w_value != want.w_value) begin
          $error("w_value expected %h got %h", want.w_value, got.w_value);
          fail_count++;
        end
        if (got.status_value != want.status_value) begin
          $error("status_value expected %h got %h", want.status_value, got.status_value);
          fail_count++;
        end
        if (got.write_valid != want.write_valid) begin
          $error("write_valid expected %b got %b", want.write_valid, got.write_valid);
          fail_count++;
        end
        if (got.write_address != want.write_address) begin
          $error("write_address expected %h got %h", want.write_address, got.write_address);
          fail_count++;
        end
        if (got.write_data != want.write_data) begin
          $error("write_data expected %h got %h", want.write_data, got.write_data);
          fail_count++;
        end
        if (got.skipped != want.skipped) begin
          $error("skipped expected %b got %b", want.skipped, got.skipped);
          fail_count++;
        end
        if (got.unsupported != want.unsupported) begin
          $error("unsupported expected %b got %b", want.unsupported, got.unsupported);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 16'h0000;
    for (int a = 0; a < FileBytes; a++) file_mem[a] = 8'h00;
    w_reg  = 8'h00;
    pc_reg = PcReset;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_literal_alu();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    test_file_regs();
    test_bits_banks();
    send_idle_on = 1'b0;
    test_branch();
    recv_idle_on = 1'b0;
    send_idle_on = 1'b1;
    test_unsupported();
    test_random_program(950);
    hold_until_retired();
    repeat (12) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
